// ===== hdl/thp_pkg.sv =====
// Shared types, constants and helper functions of the tetrahedral hydrogen placement unit.
// Used by every module of the block; depends on nothing.
package thp_pkg;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_DEGEN   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_BOND = 2'd0,
    CFG_COS  = 2'd1,
    CFG_SIN  = 2'd2
  } cfg_index_e;

  localparam logic [1:0] H_LAST = 2'd2;
  localparam logic [14:0] TILT_COS_RESET = 15'd10885;
  localparam logic [14:0] TILT_SIN_RESET = 15'd30907;
  localparam int ROOT_W = 31;
  localparam int RAD_W = 62;

  typedef struct packed {
    logic [13:0] bond_length;
    logic [14:0] tilt_cosine;
    logic [14:0] tilt_sine;
  } cfg_t;

  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    status_e status;
    vec_t    n;
    vec_t    hs;
    vec_t    ds;
  } entry_t;

  function automatic logic [35:0] mag36(input logic signed [35:0] x);
    return x < 0 ? 36'(-x) : 36'(x);
  endfunction

  function automatic logic [2:0] shrink_shift(input logic [35:0] m);
    logic [2:0] s;
    s = 3'd6;
    for (int i = 5; i >= 0; i--) begin
      if ((m >> i) < (36'd1 << 30)) s = 3'(i);
    end
    return s;
  endfunction

  function automatic vec_t shrink_vec(input logic signed [35:0] a, input logic signed [35:0] b,
                                      input logic signed [35:0] c);
    vec_t r;
    logic [2:0] sh;
    sh = shrink_shift(mag36(a) | mag36(b) | mag36(c));
    r[0] = 32'(a >>> sh);
    r[1] = 32'(b >>> sh);
    r[2] = 32'(c >>> sh);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sd2147483647) r = 32'sh7fffffff;
    else if (x < -34'sd2147483648) r = 32'sh80000000;
    else r = 32'(x);
    return r;
  endfunction

  function automatic logic [31:0] isqrt_const(input logic [63:0] n);
    logic [33:0] rem;
    logic [31:0] root;
    logic [35:0] rem2;
    logic [35:0] trial;
    rem = '0;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      rem2 = {rem, n[2*i+1 -: 2]};
      trial = {2'b00, root, 2'b01};
      if (rem2 >= trial) begin
        rem = 34'(rem2 - trial);
        root = {root[30:0], 1'b1};
      end else begin
        rem = 34'(rem2);
        root = {root[30:0], 1'b0};
      end
    end
    return root;
  endfunction

  localparam logic [31:0] KF_Q30 = isqrt_const(64'd3 << 58);

endpackage

// ===== hdl/tetrahedral_hydrogen_placement_unit.sv =====
// Top level of the tetrahedral hydrogen placement unit: configuration registers, front, queue, back.
// Depends on thp_pkg, thp_front, thp_queue and thp_back.
//
//   channel  signals                                  direction
//   in       in_valid_i / in_ready_o, 10 fields       into the block, one residue per beat
//   out      out_valid_o / out_ready_i, 6 fields      out of the block, one result per beat
//   cfg      cfg_valid_i / cfg_ready_o, index, data   into the block, one register per beat
//
// A residue with a valid frame is popped, then makes two passes through the shared square root unit
// and the three divider lanes, with projection work between the passes and cross product work
// after them; it then emits three results.
// A missing or degenerate residue yields one status result, as does one whose perpendicular vanishes.
// Results wait in the output register while out_ready_i is low, and up to QUEUE_DEPTH residues
// wait in the queue meanwhile. Reset loads the register defaults and empties queue and outputs.
module tetrahedral_hydrogen_placement_unit #(
  parameter int COORD_FRAC_BITS = 12,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               atoms_found_i,
  input  logic signed [31:0] n_x_i,
  input  logic signed [31:0] n_y_i,
  input  logic signed [31:0] n_z_i,
  input  logic signed [31:0] ca_x_i,
  input  logic signed [31:0] ca_y_i,
  input  logic signed [31:0] ca_z_i,
  input  logic signed [31:0] c_x_i,
  input  logic signed [31:0] c_y_i,
  input  logic signed [31:0] c_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         h_index_o,
  output logic signed [31:0] h_x_o,
  output logic signed [31:0] h_y_o,
  output logic signed [31:0] h_z_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import thp_pkg::*;

  localparam int BondRaw = ((108 << COORD_FRAC_BITS) + 50) / 100;
  localparam logic [13:0] BondReset = (BondRaw > 16383) ? 14'd16383 : 14'(BondRaw);

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_empty;
  entry_t push_entry, pop_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bond_length <= BondReset;
      cfg_q.tilt_cosine <= TILT_COS_RESET;
      cfg_q.tilt_sine <= TILT_SIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BOND: cfg_q.bond_length <= cfg_data_i[13:0];
        CFG_COS:  cfg_q.tilt_cosine <= cfg_data_i[14:0];
        CFG_SIN:  cfg_q.tilt_sine <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  thp_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .atoms_found_i (atoms_found_i),
    .n_x_i         (n_x_i),
    .n_y_i         (n_y_i),
    .n_z_i         (n_z_i),
    .ca_x_i        (ca_x_i),
    .ca_y_i        (ca_y_i),
    .ca_z_i        (ca_z_i),
    .c_x_i         (c_x_i),
    .c_y_i         (c_y_i),
    .c_z_i         (c_z_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  thp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (pop_entry),
    .empty_o (q_empty)
  );

  thp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .h_index_o   (h_index_o),
    .h_x_o       (h_x_o),
    .h_y_o       (h_y_o),
    .h_z_o       (h_z_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// ===== hdl/thp_front.sv =====
// Front end: accepts input beats, forms the N-CA and CA-C difference vectors and classifies them.
// Depends on thp_pkg; feeds the entry queue.
module thp_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               atoms_found_i,
  input  logic signed [31:0] n_x_i,
  input  logic signed [31:0] n_y_i,
  input  logic signed [31:0] n_z_i,
  input  logic signed [31:0] ca_x_i,
  input  logic signed [31:0] ca_y_i,
  input  logic signed [31:0] ca_z_i,
  input  logic signed [31:0] c_x_i,
  input  logic signed [31:0] c_y_i,
  input  logic signed [31:0] c_z_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output thp_pkg::entry_t    q_entry_o
);
  import thp_pkg::*;

  logic signed [35:0] dh [3];
  logic signed [35:0] dc [3];

  always_comb begin
    dh[0] = 36'(n_x_i) - 36'(ca_x_i);
    dh[1] = 36'(n_y_i) - 36'(ca_y_i);
    dh[2] = 36'(n_z_i) - 36'(ca_z_i);
    dc[0] = 36'(ca_x_i) - 36'(c_x_i);
    dc[1] = 36'(ca_y_i) - 36'(c_y_i);
    dc[2] = 36'(ca_z_i) - 36'(c_z_i);
    q_entry_o.n[0] = n_x_i;
    q_entry_o.n[1] = n_y_i;
    q_entry_o.n[2] = n_z_i;
    q_entry_o.hs = shrink_vec(dh[0], dh[1], dh[2]);
    q_entry_o.ds = shrink_vec(dc[0], dc[1], dc[2]);
    if (!atoms_found_i) begin
      q_entry_o.status = STAT_MISSING;
    end else if (dh[0] == '0 && dh[1] == '0 && dh[2] == '0) begin
      q_entry_o.status = STAT_DEGEN;
    end else begin
      q_entry_o.status = STAT_OK;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o = in_valid_i && !q_full_i;

endmodule

// ===== hdl/thp_queue.sv =====
// Short queue of classified entries between the front end and the back end.
// Depends on thp_pkg for the entry type.
module thp_queue #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  thp_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output thp_pkg::entry_t entry_o,
  output logic            empty_o
);
  import thp_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

// ===== hdl/thp_sqrt.sv =====
// Iterative integer square root, one root bit per cycle.
// Depends on thp_pkg for the operand widths.
module thp_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [thp_pkg::RAD_W-1:0]  radicand_i,
  output logic                       done_o,
  output logic [thp_pkg::ROOT_W-1:0] root_o
);
  import thp_pkg::*;

  localparam int RemW = ROOT_W + 2;
  localparam int CntW = $clog2(ROOT_W);

  logic run_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [RAD_W-1:0] rad_q;
  logic [RemW-1:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [RemW+1:0] rem2, trial;
  logic ge;

  assign rem2 = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge = rem2 >= trial;
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == CntW'(ROOT_W - 1)) begin
          run_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q <= radicand_i;
      rem_q <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q <= rad_q << 2;
      rem_q <= ge ? RemW'(rem2 - trial) : RemW'(rem2);
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/thp_div.sv =====
// Iterative signed divider lane producing one Q2.30 unit component, one quotient bit per cycle.
// Depends on thp_pkg for the root width.
module thp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [31:0]         num_i,
  input  logic [thp_pkg::ROOT_W-1:0] den_i,
  output logic                       done_o,
  output logic signed [31:0]         quo_o
);
  import thp_pkg::*;

  localparam int CntW = $clog2(ROOT_W);

  logic run_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [ROOT_W-1:0] den_q, rem_q, dvd_q, q_q;
  logic [ROOT_W:0] rem2;
  logic [31:0] a;
  logic ge;

  assign a = num_i < 0 ? 32'(-num_i) : 32'(num_i);
  assign rem2 = {rem_q, dvd_q[ROOT_W-1]};
  assign ge = rem2 >= {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == CntW'(ROOT_W - 1)) begin
          run_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i < 0;
      den_q <= den_i;
      rem_q <= ROOT_W'(a >> 1);
      dvd_q <= {a[0], 30'd0};
      q_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? ROOT_W'(rem2 - {1'b0, den_q}) : ROOT_W'(rem2);
      dvd_q <= dvd_q << 1;
      q_q <= {q_q[ROOT_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/thp_back.sv =====
// Back end: builds the local frame with the shared root unit and divider lanes, then emits results.
// Depends on thp_pkg, thp_sqrt and thp_div; drains the entry queue.
module thp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  thp_pkg::cfg_t      cfg_i,
  input  logic               q_empty_i,
  input  thp_pkg::entry_t    q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         h_index_o,
  output logic signed [31:0] h_x_o,
  output logic signed [31:0] h_y_o,
  output logic signed [31:0] h_z_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import thp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_SUM, S_ROOT, S_DIVGO, S_DIV, S_DOT, S_PROJ, S_PH, S_PERP,
    S_CROSS, S_S, S_KS, S_D, S_ACC, S_OUT, S_STAT
  } state_e;

  localparam logic signed [31:0] KfS = $signed(KF_Q30);
  localparam logic signed [65:0] RndHalf = 66'sd1 <<< 44;

  state_e state_q;
  logic phase_q, out_valid_q, last_q;
  logic [1:0] k_q, h_index_q;
  status_e stat_q, status_q;
  logic signed [31:0] hx_q, hy_q, hz_q;

  logic signed [31:0] n_q [3];
  logic signed [31:0] vec_q [3];
  logic signed [31:0] ds_q [3];
  logic signed [31:0] h_q [3];
  logic signed [31:0] v_q [3];
  logic signed [63:0] sq_q [3];
  logic signed [63:0] prod_q [3];
  logic signed [33:0] proj_q;
  logic signed [65:0] ph_q [3];
  logic signed [63:0] cp_q [6];
  logic signed [32:0] s_q [3];
  logic signed [33:0] ks_q [3];
  logic signed [47:0] csh_q [3];
  logic signed [49:0] snd_q [3];
  logic signed [65:0] bp_q [3];

  logic [RAD_W-1:0] radicand;
  logic signed [63:0] dot;
  logic signed [35:0] perp [3];
  logic signed [63:0] kp [3];
  logic signed [33:0] d [3];
  logic signed [50:0] acc [3];
  logic signed [65:0] rnd [3];
  logic signed [31:0] hc [3];
  logic signed [31:0] quo [3];
  logic [2:0] div_done;
  logic [ROOT_W-1:0] root;
  logic sqrt_done, sqrt_start, div_start, out_free, out_load;
  logic signed [15:0] cos_s, sin_s;
  logic signed [14:0] bl_s;

  assign cos_s = $signed({1'b0, cfg_i.tilt_cosine});
  assign sin_s = $signed({1'b0, cfg_i.tilt_sine});
  assign bl_s = $signed({1'b0, cfg_i.bond_length});
  assign sqrt_start = state_q == S_SUM;
  assign div_start = state_q == S_DIVGO;
  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == S_OUT || state_q == S_STAT) && out_free;

  thp_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (radicand),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    thp_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (vec_q[g]),
      .den_i   (root),
      .done_o  (div_done[g]),
      .quo_o   (quo[g])
    );
  end

  always_comb begin
    radicand = RAD_W'(sq_q[0] + sq_q[1] + sq_q[2]);
    dot = prod_q[0] + prod_q[1] + prod_q[2];
    for (int i = 0; i < 3; i++) begin
      perp[i] = 36'(ds_q[i]) - 36'(ph_q[i] >>> 30);
      kp[i] = KfS * s_q[i];
      if (k_q == 2'd0) begin
        d[i] = 34'(v_q[i]);
      end else if (k_q == 2'd1) begin
        d[i] = ks_q[i] - 34'(v_q[i] >>> 1);
      end else begin
        d[i] = -ks_q[i] - 34'(v_q[i] >>> 1);
      end
      acc[i] = 51'(csh_q[i]) + 51'(snd_q[i]);
      rnd[i] = bp_q[i] + RndHalf;
      hc[i] = sat32(34'(n_q[i]) + 34'(rnd[i] >>> 45));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
      k_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          phase_q <= 1'b0;
          if (!q_empty_i) state_q <= (q_entry_i.status == STAT_OK) ? S_SQ : S_STAT;
        end
        S_SQ: state_q <= S_SUM;
        S_SUM: state_q <= S_ROOT;
        S_ROOT: begin
          if (sqrt_done) state_q <= (root == '0) ? S_STAT : S_DIVGO;
        end
        S_DIVGO: state_q <= S_DIV;
        S_DIV: begin
          if (div_done[0]) state_q <= phase_q ? S_CROSS : S_DOT;
        end
        S_DOT: state_q <= S_PROJ;
        S_PROJ: state_q <= S_PH;
        S_PH: state_q <= S_PERP;
        S_PERP: begin
          phase_q <= 1'b1;
          state_q <= S_SQ;
        end
        S_CROSS: state_q <= S_S;
        S_S: state_q <= S_KS;
        S_KS: begin
          k_q <= '0;
          state_q <= S_D;
        end
        S_D: state_q <= S_ACC;
        S_ACC: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            if (k_q == H_LAST) begin
              state_q <= S_IDLE;
            end else begin
              k_q <= k_q + 1'b1;
              state_q <= S_D;
            end
          end
        end
        S_STAT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      stat_q <= q_entry_i.status;
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= $signed(q_entry_i.n[i]);
        vec_q[i] <= $signed(q_entry_i.hs[i]);
        ds_q[i] <= $signed(q_entry_i.ds[i]);
      end
    end
    if (state_q == S_ROOT && sqrt_done && root == '0) stat_q <= STAT_DEGEN;
    for (int i = 0; i < 3; i++) begin
      if (state_q == S_SQ) sq_q[i] <= vec_q[i] * vec_q[i];
      if (state_q == S_DIV && div_done[0]) begin
        if (phase_q) v_q[i] <= quo[i];
        else h_q[i] <= quo[i];
      end
      if (state_q == S_DOT) prod_q[i] <= ds_q[i] * h_q[i];
      if (state_q == S_PH) ph_q[i] <= proj_q * h_q[i];
      if (state_q == S_KS) begin
        ks_q[i] <= 34'(kp[i] >>> 30);
        csh_q[i] <= cos_s * h_q[i];
      end
      if (state_q == S_D) snd_q[i] <= sin_s * d[i];
      if (state_q == S_ACC) bp_q[i] <= bl_s * acc[i];
    end
    if (state_q == S_PROJ) proj_q <= 34'(dot >>> 30);
    if (state_q == S_PERP) begin
      {vec_q[2], vec_q[1], vec_q[0]} <= shrink_vec(perp[0], perp[1], perp[2]);
    end
    if (state_q == S_CROSS) begin
      cp_q[0] <= h_q[1] * v_q[2];
      cp_q[1] <= h_q[2] * v_q[1];
      cp_q[2] <= h_q[2] * v_q[0];
      cp_q[3] <= h_q[0] * v_q[2];
      cp_q[4] <= h_q[0] * v_q[1];
      cp_q[5] <= h_q[1] * v_q[0];
    end
    if (state_q == S_S) begin
      s_q[0] <= 33'((cp_q[0] - cp_q[1]) >>> 30);
      s_q[1] <= 33'((cp_q[2] - cp_q[3]) >>> 30);
      s_q[2] <= 33'((cp_q[4] - cp_q[5]) >>> 30);
    end
    if (out_load) begin
      if (state_q == S_STAT) begin
        h_index_q <= '0;
        hx_q <= '0;
        hy_q <= '0;
        hz_q <= '0;
        status_q <= stat_q;
        last_q <= 1'b1;
      end else begin
        h_index_q <= k_q;
        hx_q <= hc[0];
        hy_q <= hc[1];
        hz_q <= hc[2];
        status_q <= STAT_OK;
        last_q <= k_q == H_LAST;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign h_index_o = h_index_q;
  assign h_x_o = hx_q;
  assign h_y_o = hy_q;
  assign h_z_o = hz_q;
  assign status_o = status_q;
  assign last_o = last_q;

endmodule
